// ===== rtl/core/gltt_pkg.sv =====
package gltt_pkg;

    localparam int IN_BITS    = 24;
    localparam int FRAC_BITS  = 8;
    localparam int TILE_BITS  = 16;
    localparam int MAX_TILES  = 64;
    localparam int OUT_TILE_W = 16;

    localparam int CNT_W    = $clog2(MAX_TILES + 1);
    localparam int FRAC_W   = FRAC_BITS + 1;
    localparam int DIFF_W   = IN_BITS + 1;
    localparam int TC_W     = IN_BITS - FRAC_BITS;
    localparam int TD_W     = TC_W + 1;
    localparam int LEN_W    = TD_W + 1;
    localparam int PROD_W   = FRAC_W + DIFF_W;
    localparam int INCR_W   = DIFF_W + FRAC_BITS;
    localparam int DIST_W   = PROD_W + $clog2(MAX_TILES);
    localparam int S_DATA_W = ((4 * IN_BITS + 7) / 8) * 8;
    localparam int M_DATA_W = ((2 * OUT_TILE_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_WALK
    } ctrl_state_t;

    typedef enum logic [1:0] {
        LM_ROW,
        LM_COL,
        LM_GEN
    } line_mode_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic final_tile;
    } dp_stat_t;

endpackage

// ===== rtl/core/grid_line_tile_traversal.sv =====
// the line word is registered on acceptance, the PREP state forms the distance products,
// and each WALK step loads one tile into the output register, one tile per cycle while the
// output is not stalled; a line is cut at 64 tiles
// the next line word is taken as soon as the last tile is loaded into the output register
// reset: synchronous active-low aresetn clears the controller and output valid
module grid_line_tile_traversal (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // start_x, start_y, end_x, end_y
    input  logic [gltt_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tile_x, tile_y
    output logic [gltt_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    // truncated
    output logic [0:0]                    m_tuser
);

    gltt_pkg::dp_cmd_t  cmd;
    gltt_pkg::dp_stat_t stat;

    gltt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    gltt_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

endmodule

// ===== rtl/core/gltt_ctrl.sv =====
module gltt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output gltt_pkg::dp_cmd_t  cmd,
    input  gltt_pkg::dp_stat_t stat
);

    gltt_pkg::ctrl_state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gltt_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            gltt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = gltt_pkg::ST_PREP;
                end
            end
            gltt_pkg::ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = gltt_pkg::ST_WALK;
            end
            gltt_pkg::ST_WALK: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.step = 1'b1;
                    if (stat.final_tile) begin
                        state_next = gltt_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = gltt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.step) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

// ===== rtl/core/gltt_dpath.sv =====
module gltt_dpath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  gltt_pkg::dp_cmd_t               cmd,
    output gltt_pkg::dp_stat_t              stat,
    input  logic [gltt_pkg::S_DATA_W-1:0]   s_tdata,
    output logic [gltt_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    output logic [0:0]                      m_tuser
);

    localparam logic [gltt_pkg::FRAC_W-1:0] ONE_FX =
        gltt_pkg::FRAC_W'(1 << gltt_pkg::FRAC_BITS);
    localparam logic [gltt_pkg::FRAC_W-1:0] FRAC_MASK =
        gltt_pkg::FRAC_W'((1 << gltt_pkg::FRAC_BITS) - 1);

    // input unpack
    logic signed [gltt_pkg::IN_BITS-1:0] sx, sy, ex, ey;
    logic signed [gltt_pkg::TC_W-1:0]    tsx, tsy, tex, tey;
    logic [gltt_pkg::FRAC_W-1:0]         fsx, fsy, fx_c, fy_c;
    logic signed [gltt_pkg::DIFF_W-1:0]  dx, dy;
    logic [gltt_pkg::DIFF_W-1:0]         adx_c, ady_c;
    logic signed [gltt_pkg::TD_W-1:0]    tdx, tdy;
    logic [gltt_pkg::TD_W-1:0]           atdx, atdy;
    logic [gltt_pkg::LEN_W-1:0]          span;
    logic                                trunc_c;
    gltt_pkg::line_mode_t                mode_c;

    assign sx = s_tdata[gltt_pkg::IN_BITS-1:0];
    assign sy = s_tdata[2*gltt_pkg::IN_BITS-1:gltt_pkg::IN_BITS];
    assign ex = s_tdata[3*gltt_pkg::IN_BITS-1:2*gltt_pkg::IN_BITS];
    assign ey = s_tdata[4*gltt_pkg::IN_BITS-1:3*gltt_pkg::IN_BITS];

    assign tsx = gltt_pkg::TC_W'(sx >>> gltt_pkg::FRAC_BITS);
    assign tsy = gltt_pkg::TC_W'(sy >>> gltt_pkg::FRAC_BITS);
    assign tex = gltt_pkg::TC_W'(ex >>> gltt_pkg::FRAC_BITS);
    assign tey = gltt_pkg::TC_W'(ey >>> gltt_pkg::FRAC_BITS);

    assign fsx = gltt_pkg::FRAC_W'($unsigned(sx)) & FRAC_MASK;
    assign fsy = gltt_pkg::FRAC_W'($unsigned(sy)) & FRAC_MASK;

    assign dx = gltt_pkg::DIFF_W'(ex) - gltt_pkg::DIFF_W'(sx);
    assign dy = gltt_pkg::DIFF_W'(ey) - gltt_pkg::DIFF_W'(sy);
    assign adx_c = dx[gltt_pkg::DIFF_W-1] ? $unsigned(-dx) : $unsigned(dx);
    assign ady_c = dy[gltt_pkg::DIFF_W-1] ? $unsigned(-dy) : $unsigned(dy);
    assign fx_c = dx[gltt_pkg::DIFF_W-1] ? fsx : ONE_FX - fsx;
    assign fy_c = dy[gltt_pkg::DIFF_W-1] ? fsy : ONE_FX - fsy;

    assign tdx  = gltt_pkg::TD_W'(tex) - gltt_pkg::TD_W'(tsx);
    assign tdy  = gltt_pkg::TD_W'(tey) - gltt_pkg::TD_W'(tsy);
    assign atdx = tdx[gltt_pkg::TD_W-1] ? $unsigned(-tdx) : $unsigned(tdx);
    assign atdy = tdy[gltt_pkg::TD_W-1] ? $unsigned(-tdy) : $unsigned(tdy);
    assign span = gltt_pkg::LEN_W'(atdx) + gltt_pkg::LEN_W'(atdy);
    assign trunc_c = span >= gltt_pkg::LEN_W'(gltt_pkg::MAX_TILES);

    always_comb begin
        if (tsy == tey) begin
            mode_c = gltt_pkg::LM_ROW;
        end else if (tsx == tex) begin
            mode_c = gltt_pkg::LM_COL;
        end else begin
            mode_c = gltt_pkg::LM_GEN;
        end
    end

    // line state
    logic                              neg_x_reg, neg_y_reg, trunc_reg;
    logic [gltt_pkg::DIFF_W-1:0]       adx_reg, ady_reg;
    logic [gltt_pkg::FRAC_W-1:0]       fx_reg, fy_reg;
    gltt_pkg::line_mode_t              mode_reg;
    logic [gltt_pkg::CNT_W-1:0]        left_reg;
    logic [gltt_pkg::TILE_BITS-1:0]    tile_x_reg, tile_y_reg;
    logic [gltt_pkg::DIST_W-1:0]       dist_x_reg, dist_y_reg;
    logic [gltt_pkg::INCR_W-1:0]       incr_x_reg, incr_y_reg;
    logic [gltt_pkg::OUT_TILE_W-1:0]   out_x_reg, out_y_reg;
    logic                              out_last_reg, out_trunc_reg;

    logic [gltt_pkg::PROD_W-1:0]       prod_x, prod_y;
    logic                              move_x;

    assign prod_x = gltt_pkg::PROD_W'(fx_reg) * gltt_pkg::PROD_W'(ady_reg);
    assign prod_y = gltt_pkg::PROD_W'(fy_reg) * gltt_pkg::PROD_W'(adx_reg);

    assign move_x = (mode_reg == gltt_pkg::LM_ROW) ||
                    ((mode_reg == gltt_pkg::LM_GEN) && (dist_x_reg < dist_y_reg));

    assign stat.final_tile = left_reg == gltt_pkg::CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else if (cmd.load) begin
            left_reg <= trunc_c ? gltt_pkg::CNT_W'(gltt_pkg::MAX_TILES)
                                : gltt_pkg::CNT_W'(span + gltt_pkg::LEN_W'(1));
        end else if (cmd.step) begin
            left_reg <= left_reg - gltt_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            neg_x_reg  <= dx[gltt_pkg::DIFF_W-1];
            neg_y_reg  <= dy[gltt_pkg::DIFF_W-1];
            trunc_reg  <= trunc_c;
            adx_reg    <= adx_c;
            ady_reg    <= ady_c;
            fx_reg     <= fx_c;
            fy_reg     <= fy_c;
            mode_reg   <= mode_c;
            tile_x_reg <= gltt_pkg::TILE_BITS'(tsx);
            tile_y_reg <= gltt_pkg::TILE_BITS'(tsy);
        end
        if (cmd.prep) begin
            dist_x_reg <= gltt_pkg::DIST_W'(prod_x);
            dist_y_reg <= gltt_pkg::DIST_W'(prod_y);
            incr_x_reg <= gltt_pkg::INCR_W'(ady_reg) << gltt_pkg::FRAC_BITS;
            incr_y_reg <= gltt_pkg::INCR_W'(adx_reg) << gltt_pkg::FRAC_BITS;
        end
        if (cmd.step) begin
            out_x_reg     <= gltt_pkg::OUT_TILE_W'($signed(tile_x_reg));
            out_y_reg     <= gltt_pkg::OUT_TILE_W'($signed(tile_y_reg));
            out_last_reg  <= stat.final_tile;
            out_trunc_reg <= trunc_reg;
            if (move_x) begin
                tile_x_reg <= neg_x_reg ? tile_x_reg - gltt_pkg::TILE_BITS'(1)
                                        : tile_x_reg + gltt_pkg::TILE_BITS'(1);
                if (mode_reg == gltt_pkg::LM_GEN) begin
                    dist_x_reg <= dist_x_reg + gltt_pkg::DIST_W'(incr_x_reg);
                end
            end else begin
                tile_y_reg <= neg_y_reg ? tile_y_reg - gltt_pkg::TILE_BITS'(1)
                                        : tile_y_reg + gltt_pkg::TILE_BITS'(1);
                if (mode_reg == gltt_pkg::LM_GEN) begin
                    dist_y_reg <= dist_y_reg + gltt_pkg::DIST_W'(incr_y_reg);
                end
            end
        end
    end

    assign m_tdata = gltt_pkg::M_DATA_W'({out_y_reg, out_x_reg});
    assign m_tlast = out_last_reg;
    assign m_tuser = out_trunc_reg;

endmodule
